// ===== hdl/lmf_pkg.sv =====
// Shared constants, types and register codes of the line mask flatness filter.
package lmf_pkg;

  // Largest supported image width; the line store depth follows from it.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int THR_W     = 11;
  localparam int ROW_W     = 11;
  localparam int OUT_COL_W = 11;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
  localparam int SIZE_W    = (WIDTH_W > CFG_W) ? WIDTH_W : CFG_W;
  localparam int SUM_W     = PIX_W + 2;
  localparam int RESP_W    = SUM_W + 2;
  localparam int IDX_W     = 2;

  // Result queue sizing.
  localparam int QUEUE_DEPTH = 16;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = QA_W + 1;
  localparam int MAX_PUSH    = 3;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_FLAT_THRESHOLD = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 12'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 12'd480;
  localparam logic [THR_W-1:0] RST_FLAT_THRESHOLD = 11'd30;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // One window column: top, middle and bottom pixel.
  typedef logic [2:0][PIX_W-1:0] col_t;

  // Contents of one window cell: its column and the column sum.
  typedef struct packed {
    col_t             pix;
    logic [SUM_W-1:0] sum;
  } cell_t;

  // One result item.
  typedef struct packed {
    logic                 last;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic [PIX_W-1:0]     value;
  } result_t;

  // Up to three results handed to the queue in one cycle, in order.
  typedef struct packed {
    logic    [MAX_PUSH-1:0] valid;
    result_t [MAX_PUSH-1:0] item;
  } push_t;

endpackage

// ===== hdl/line_mask_flatness_filter.sv =====
// Top level of the line mask flatness filter: counters, window chain, filter and queue.
// Pipeline: a pixel passes stage one, then stage two, where its results are formed and
// written into the result queue (results trail by a row and a column).
// Throughput: one pixel per cycle inside the image, unless s_tready drops; the last row
// gives two results per pixel, so there the one-result-per-cycle output port sets the pace.
// Reset: rst clears counters, pipeline, queue and window and restores register defaults;
// line store contents are undefined until written.
module line_mask_flatness_filter (
  input  logic                         clk,
  input  logic                         rst,
  // Input pixels. s_tdata: pixel [7:0].
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,
  // Results. m_tdata: out_value [7:0], out_row [18:8], out_col [29:19], zero [31:30].
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,
  output logic                         m_tlast,
  // Configuration writes.
  input  logic                         wr_en,
  input  logic [lmf_pkg::IDX_W-1:0]    wr_index,
  input  logic [lmf_pkg::CFG_W-1:0]    wr_data
);

  // Configuration registers.
  logic [lmf_pkg::CFG_W-1:0] image_width;
  logic [lmf_pkg::CFG_W-1:0] image_height;
  logic [lmf_pkg::THR_W-1:0] flat_threshold;

  // Position of the next input pixel.
  logic [lmf_pkg::ROW_W-1:0] row_count;
  logic [lmf_pkg::COL_W-1:0] col_count;

  logic [lmf_pkg::SIZE_W-1:0] w_eff;
  logic [lmf_pkg::SIZE_W-1:0] w_raw;
  logic [lmf_pkg::CFG_W-1:0]  h_eff;
  logic                       in_acc;
  logic                       col_wrap;
  logic                       row_wrap;

  // Stage one: line store data arrives.
  logic                       s1_valid;
  logic [lmf_pkg::PIX_W-1:0]  s1_px;
  logic [lmf_pkg::ROW_W-1:0]  s1_r;
  logic [lmf_pkg::COL_W-1:0]  s1_c;
  logic [4:0]                 s1_flags;
  logic [2*lmf_pkg::PIX_W-1:0] rd_data;
  logic [lmf_pkg::PIX_W-1:0]  up1;
  logic [lmf_pkg::PIX_W-1:0]  up2;
  logic [4:0]                 flags;

  // Stage two: window ready, results formed.
  logic                       s2_valid;
  logic [lmf_pkg::PIX_W-1:0]  s2_px;
  logic [lmf_pkg::PIX_W-1:0]  s2_up1;
  logic [lmf_pkg::ROW_W-1:0]  s2_r;
  logic [lmf_pkg::COL_W-1:0]  s2_c;
  logic [4:0]                 s2_flags;

  lmf_pkg::col_t    new_col;
  lmf_pkg::cell_t   cells [3];
  lmf_pkg::push_t   push;
  lmf_pkg::result_t q_item;
  logic [lmf_pkg::QC_W-1:0] q_count;
  logic [lmf_pkg::QC_W:0]   reserve;

  logic [lmf_pkg::SUM_W-1:0]  rows [3];
  logic [lmf_pkg::RESP_W-1:0] hr;
  logic [lmf_pkg::RESP_W-1:0] vr;
  logic [lmf_pkg::RESP_W-1:0] hr_abs;
  logic [lmf_pkg::RESP_W-1:0] vr_abs;
  logic                       flat;
  logic [lmf_pkg::PIX_W-1:0]  centre_value;

  // Flag positions.
  localparam int F_R1  = 0;  // row at least 1
  localparam int F_C1  = 1;  // column at least 1
  localparam int F_IN  = 2;  // interior centre
  localparam int F_EOL = 3;  // last column
  localparam int F_EOI = 4;  // last row

  // Effective image size.
  assign w_raw = lmf_pkg::SIZE_W'(image_width);
  always_comb begin
    if (w_raw < lmf_pkg::SIZE_W'(3)) begin
      w_eff = lmf_pkg::SIZE_W'(3);
    end else if (w_raw > lmf_pkg::SIZE_W'(lmf_pkg::MAX_WIDTH)) begin
      w_eff = lmf_pkg::SIZE_W'(lmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (image_height < lmf_pkg::CFG_W'(3)) begin
      h_eff = lmf_pkg::CFG_W'(3);
    end else if (image_height > lmf_pkg::CFG_W'(lmf_pkg::MAX_HEIGHT)) begin
      h_eff = lmf_pkg::CFG_W'(lmf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // Admit a pixel only if the queue can hold every result still in flight.
  always_comb begin
    reserve = (lmf_pkg::QC_W+1)'(q_count) + (lmf_pkg::QC_W+1)'(lmf_pkg::MAX_PUSH);
    if (s1_valid) begin
      reserve = reserve + (lmf_pkg::QC_W+1)'(lmf_pkg::MAX_PUSH);
    end
    if (s2_valid) begin
      reserve = reserve + (lmf_pkg::QC_W+1)'(lmf_pkg::MAX_PUSH);
    end
  end
  assign s_tready = (reserve <= (lmf_pkg::QC_W+1)'(lmf_pkg::QUEUE_DEPTH));
  assign in_acc   = s_tvalid && s_tready;

  // Position flags of the incoming pixel.
  always_comb begin
    flags[F_R1]  = (row_count != '0);
    flags[F_C1]  = (col_count != '0);
    flags[F_IN]  = (row_count >= lmf_pkg::ROW_W'(2)) && (col_count >= lmf_pkg::COL_W'(2));
    flags[F_EOL] = (lmf_pkg::SIZE_W'(col_count) == w_eff - 1'b1);
    flags[F_EOI] = (lmf_pkg::CFG_W'(row_count) == h_eff - 1'b1);
    col_wrap     = (lmf_pkg::SIZE_W'(col_count) + 1'b1 >= w_eff);
    row_wrap     = (lmf_pkg::CFG_W'(row_count) + 1'b1 >= h_eff);
  end

  // Configuration registers and raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= lmf_pkg::RST_IMAGE_WIDTH;
      image_height   <= lmf_pkg::RST_IMAGE_HEIGHT;
      flat_threshold <= lmf_pkg::RST_FLAT_THRESHOLD;
      row_count      <= '0;
      col_count      <= '0;
    end else if (wr_en) begin
      case (wr_index)
        lmf_pkg::REG_IMAGE_WIDTH: begin
          image_width <= wr_data;
          row_count   <= '0;
          col_count   <= '0;
        end
        lmf_pkg::REG_IMAGE_HEIGHT: begin
          image_height <= wr_data;
          row_count    <= '0;
          col_count    <= '0;
        end
        lmf_pkg::REG_FLAT_THRESHOLD: begin
          flat_threshold <= wr_data[lmf_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // Line stores: read at the pixel's column, written back from stage one in the next cycle.
  assign up1 = rd_data[lmf_pkg::PIX_W-1:0];
  assign up2 = rd_data[2*lmf_pkg::PIX_W-1:lmf_pkg::PIX_W];

  lmf_line_store u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_count),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_c),
    .wr_data ({up1, s1_px})
  );

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px    <= s_tdata;
      s1_r     <= row_count;
      s1_c     <= col_count;
      s1_flags <= flags;
    end
    if (s1_valid) begin
      s2_px    <= s1_px;
      s2_up1   <= up1;
      s2_r     <= s1_r;
      s2_c     <= s1_c;
      s2_flags <= s1_flags;
    end
  end

  // Window chain: the newest column enters cell 0 and moves left each pixel.
  assign new_col[0] = up2;
  assign new_col[1] = up1;
  assign new_col[2] = s1_px;

  lmf_window_cell u_cell0 (
    .clk(clk), .rst(rst), .shift(s1_valid), .col_in(new_col), .cell_out(cells[0])
  );
  lmf_window_cell u_cell1 (
    .clk(clk), .rst(rst), .shift(s1_valid), .col_in(cells[0].pix), .cell_out(cells[1])
  );
  lmf_window_cell u_cell2 (
    .clk(clk), .rst(rst), .shift(s1_valid), .col_in(cells[1].pix), .cell_out(cells[2])
  );

  // Row and column responses of the window and the flatness decision.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rows[i] = lmf_pkg::SUM_W'(cells[0].pix[i]) + lmf_pkg::SUM_W'(cells[1].pix[i])
              + lmf_pkg::SUM_W'(cells[2].pix[i]);
    end
    hr = (lmf_pkg::RESP_W'(rows[1]) << 1) - lmf_pkg::RESP_W'(rows[0])
       - lmf_pkg::RESP_W'(rows[2]);
    vr = (lmf_pkg::RESP_W'(cells[1].sum) << 1) - lmf_pkg::RESP_W'(cells[0].sum)
       - lmf_pkg::RESP_W'(cells[2].sum);
    hr_abs = hr[lmf_pkg::RESP_W-1] ? -hr : hr;
    vr_abs = vr[lmf_pkg::RESP_W-1] ? -vr : vr;
    flat = (hr_abs < lmf_pkg::RESP_W'(flat_threshold))
        && (vr_abs < lmf_pkg::RESP_W'(flat_threshold));
    if (s2_flags[F_IN] && flat) begin
      centre_value = '0;
    end else begin
      centre_value = lmf_pkg::PIX_MAX - cells[1].pix[1];
    end
  end

  // Results of the pixel in stage two, in order, the last one marked.
  always_comb begin
    push.valid[0] = s2_valid && s2_flags[F_R1] && s2_flags[F_C1];
    push.valid[1] = s2_valid && s2_flags[F_R1] && s2_flags[F_EOL];
    push.valid[2] = s2_valid && s2_flags[F_EOI];

    push.item[0].value = centre_value;
    push.item[0].row   = s2_r - 1'b1;
    push.item[0].col   = lmf_pkg::OUT_COL_W'(s2_c - 1'b1);
    push.item[0].last  = !push.valid[1] && !push.valid[2];

    push.item[1].value = lmf_pkg::PIX_MAX - s2_up1;
    push.item[1].row   = s2_r - 1'b1;
    push.item[1].col   = lmf_pkg::OUT_COL_W'(s2_c);
    push.item[1].last  = !push.valid[2];

    push.item[2].value = lmf_pkg::PIX_MAX - s2_px;
    push.item[2].row   = s2_r;
    push.item[2].col   = lmf_pkg::OUT_COL_W'(s2_c);
    push.item[2].last  = 1'b1;
  end

  lmf_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (q_item),
    .count     (q_count)
  );

  // Output packing.
  assign m_tdata = {2'b00, q_item.col, q_item.row, q_item.value};
  assign m_tlast = q_item.last;

endmodule

// ===== hdl/lmf_line_store.sv =====
// Line store memory: previous row and the row before it, one word per column.
module lmf_line_store (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [lmf_pkg::COL_W-1:0]     rd_addr,
  output logic [2*lmf_pkg::PIX_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [lmf_pkg::COL_W-1:0]     wr_addr,
  input  logic [2*lmf_pkg::PIX_W-1:0]   wr_data
);

  // Upper byte holds the older row, lower byte the previous row.
  logic [2*lmf_pkg::PIX_W-1:0] mem [lmf_pkg::MAX_WIDTH];

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== hdl/lmf_window_cell.sv =====
// One cell of the 3x3 window chain: holds a pixel column and its sum.
module lmf_window_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  lmf_pkg::col_t  col_in,
  output lmf_pkg::cell_t cell_out
);

  logic [lmf_pkg::SUM_W-1:0] col_sum;

  // Column sum of the incoming pixels.
  assign col_sum = lmf_pkg::SUM_W'(col_in[0]) + lmf_pkg::SUM_W'(col_in[1])
                 + lmf_pkg::SUM_W'(col_in[2]);

  // Take the incoming column and its sum on every shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out <= '0;
    end else if (shift) begin
      cell_out.pix <= col_in;
      cell_out.sum <= col_sum;
    end
  end

endmodule

// ===== hdl/lmf_result_queue.sv =====
// Result queue that takes up to three results a cycle and hands out one.
module lmf_result_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  lmf_pkg::push_t             push,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lmf_pkg::result_t           out_item,
  output logic [lmf_pkg::QC_W-1:0]   count
);

  lmf_pkg::result_t          mem [lmf_pkg::QUEUE_DEPTH];
  logic [lmf_pkg::QA_W-1:0]  wr_ptr;
  logic [lmf_pkg::QA_W-1:0]  rd_ptr;
  logic [lmf_pkg::QA_W-1:0]  offs [lmf_pkg::MAX_PUSH];
  logic [lmf_pkg::QC_W-1:0]  npush;
  logic                      pop;

  // Each valid result goes to the slot after the valid ones before it.
  always_comb begin
    offs[0] = '0;
    offs[1] = lmf_pkg::QA_W'(push.valid[0]);
    offs[2] = lmf_pkg::QA_W'(push.valid[0]) + lmf_pkg::QA_W'(push.valid[1]);
    npush   = lmf_pkg::QC_W'(push.valid[0]) + lmf_pkg::QC_W'(push.valid[1])
            + lmf_pkg::QC_W'(push.valid[2]);
  end

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Storage writes.
  always_ff @(posedge clk) begin
    for (int k = 0; k < lmf_pkg::MAX_PUSH; k++) begin
      if (push.valid[k]) begin
        mem[wr_ptr + offs[k]] <= push.item[k];
      end
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + lmf_pkg::QA_W'(npush);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + npush - lmf_pkg::QC_W'(pop);
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the line mask flatness filter: stream driver, monitor, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_GAP    = 8;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 380;

  // Index past the end of the register list; the block must ignore it.
  localparam logic [lmf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_EXTREME} pixel_style_t;

  // Predicts the filtered raster and checks the block's results in order.
  class flatness_scoreboard;
    logic [lmf_pkg::CFG_W-1:0] width_reg;
    logic [lmf_pkg::CFG_W-1:0] height_reg;
    logic [lmf_pkg::THR_W-1:0] thresh_reg;
    logic [lmf_pkg::PIX_W-1:0] prev_line [lmf_pkg::MAX_WIDTH];
    logic [lmf_pkg::PIX_W-1:0] older_line [lmf_pkg::MAX_WIDTH];
    logic [lmf_pkg::PIX_W-1:0] win [3][3];
    int unsigned               row_pos;
    int unsigned               col_pos;
    lmf_pkg::result_t          expected_q [$];
    int                        mismatches;

    function new();
      width_reg  = lmf_pkg::RST_IMAGE_WIDTH;
      height_reg = lmf_pkg::RST_IMAGE_HEIGHT;
      thresh_reg = lmf_pkg::RST_FLAT_THRESHOLD;
      foreach (prev_line[i]) begin
        prev_line[i]  = '0;
        older_line[i] = '0;
      end
      foreach (win[i, k]) win[i][k] = '0;
      row_pos    = 0;
      col_pos    = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // A size write restarts the image; a threshold write takes effect at once.
    function void apply_write(logic [lmf_pkg::IDX_W-1:0] idx,
                              logic [lmf_pkg::CFG_W-1:0] data);
      case (idx)
        lmf_pkg::REG_IMAGE_WIDTH: begin
          width_reg = data;
          row_pos   = 0;
          col_pos   = 0;
        end
        lmf_pkg::REG_IMAGE_HEIGHT: begin
          height_reg = data;
          row_pos    = 0;
          col_pos    = 0;
        end
        lmf_pkg::REG_FLAT_THRESHOLD: thresh_reg = data[lmf_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Shifts one pixel into the line stores and window and queues its results.
    function void note_pixel(logic [lmf_pkg::PIX_W-1:0] px);
      int unsigned               w, h, r, c;
      logic [lmf_pkg::PIX_W-1:0] up1, up2, centre_val;
      int                        rsum [3];
      int                        csum [3];
      int                        hresp, vresp, i, k;
      lmf_pkg::result_t          res [$];
      lmf_pkg::result_t          item;
      w = clamp_size(width_reg, lmf_pkg::MAX_WIDTH);
      h = clamp_size(height_reg, lmf_pkg::MAX_HEIGHT);
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;

      up1 = prev_line[c];
      up2 = older_line[c];
      older_line[c] = up1;
      prev_line[c]  = px;
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;

      // Centre one row up and one column left; filtered only when fully interior.
      if (r >= 1 && c >= 1) begin
        centre_val = lmf_pkg::PIX_MAX - win[1][1];
        if (r >= 2 && c >= 2) begin
          for (i = 0; i < 3; i++) begin
            rsum[i] = 0;
            csum[i] = 0;
            for (k = 0; k < 3; k++) begin
              rsum[i] += int'(win[i][k]);
              csum[i] += int'(win[k][i]);
            end
          end
          hresp = 2 * rsum[1] - rsum[0] - rsum[2];
          vresp = 2 * csum[1] - csum[0] - csum[2];
          if (hresp < 0) hresp = -hresp;
          if (vresp < 0) vresp = -vresp;
          if (hresp < int'(thresh_reg) && vresp < int'(thresh_reg)) centre_val = '0;
        end
        item.last  = 1'b0;
        item.col   = lmf_pkg::OUT_COL_W'(c - 1);
        item.row   = lmf_pkg::ROW_W'(r - 1);
        item.value = centre_val;
        res.push_back(item);
      end
      // The right border pixel of the row above comes out with the row's last pixel.
      if (r >= 1 && c == w - 1) begin
        item.last  = 1'b0;
        item.col   = lmf_pkg::OUT_COL_W'(w - 1);
        item.row   = lmf_pkg::ROW_W'(r - 1);
        item.value = lmf_pkg::PIX_MAX - up1;
        res.push_back(item);
      end
      // The last row passes straight through.
      if (r == h - 1) begin
        item.last  = 1'b0;
        item.col   = lmf_pkg::OUT_COL_W'(c);
        item.row   = lmf_pkg::ROW_W'(r);
        item.value = lmf_pkg::PIX_MAX - px;
        res.push_back(item);
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[j]) expected_q.push_back(res[j]);

      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    // Compares one result transaction with the oldest prediction.
    function void check_result(lmf_pkg::result_t got);
      lmf_pkg::result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value %0d row %0d col %0d last %0b",
                   got.value, got.row, got.col, got.last);
      end else begin
        want = expected_q.pop_front();
        if (got.value !== want.value || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected value %0d row %0d col %0d last %0b,",
                      " got value %0d row %0d col %0d last %0b"},
                     want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
        end
      end
    endfunction
  endclass

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [7:0]                s_tdata  = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [31:0]               m_tdata;
  logic                      m_tlast;
  logic                      wr_en    = 1'b0;
  logic [lmf_pkg::IDX_W-1:0] wr_index = '0;
  logic [lmf_pkg::CFG_W-1:0] wr_data  = '0;
  bit                        steady_flow = 1'b0;
  int unsigned               cycle_count = 0;

  flatness_scoreboard board = new();

  line_mask_flatness_filter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Monitor: register writes, pixel and result transactions at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) board.apply_write(wr_index, wr_data);
      if (s_tvalid && s_tready) board.note_pixel(s_tdata);
      if (m_tvalid && m_tready)
        board.check_result(lmf_pkg::result_t'({m_tlast, m_tdata[29:19], m_tdata[18:8],
                                                m_tdata[7:0]}));
    end
  end

  // Result sink with a random stall before each transaction, unless steady flow is set.
  initial begin : result_sink
    int stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Offers one pixel after a random gap (none in steady flow) and waits for its transaction.
  task automatic send_pixel(input logic [lmf_pkg::PIX_W-1:0] px);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds off the sender until every predicted result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // One register write, strobed for a single cycle.
  task automatic write_reg(input logic [lmf_pkg::IDX_W-1:0] idx,
                           input logic [lmf_pkg::CFG_W-1:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  function automatic logic [lmf_pkg::PIX_W-1:0] draw_pixel(pixel_style_t style, int base);
    int v;
    case (style)
      PIX_SMOOTH: begin
        v = base + $urandom_range(0, 7);
        if (v > 255) v = 255;
        return lmf_pkg::PIX_W'(v);
      end
      PIX_EXTREME: return $urandom_range(0, 1) ? lmf_pkg::PIX_MAX : '0;
      default: return lmf_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Configures an image and streams pixels, with occasional drained pauses.
  task automatic run_phase(input logic [lmf_pkg::CFG_W-1:0] w,
                           input logic [lmf_pkg::CFG_W-1:0] h,
                           input logic [lmf_pkg::CFG_W-1:0] thr, input int count,
                           input pixel_style_t style);
    int base, i;
    wait_drained();
    write_reg(lmf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(lmf_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(lmf_pkg::REG_FLAT_THRESHOLD, thr);
    base = $urandom_range(0, 255);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 79) == 0) begin
        wait_drained();
        case ($urandom_range(0, 3))
          0: write_reg(lmf_pkg::REG_FLAT_THRESHOLD,
                       lmf_pkg::CFG_W'($urandom_range(0, 4095)));
          1: write_reg(REG_UNUSED, lmf_pkg::CFG_W'($urandom_range(0, 4095)));
          2: write_reg(lmf_pkg::REG_IMAGE_WIDTH, w);
          default: ;
        endcase
      end
      send_pixel(draw_pixel(style, base));
    end
  endtask

  // Main sequence.
  initial begin : stimulus
    logic [lmf_pkg::PIX_W-1:0] checker_px [9];
    logic [lmf_pkg::PIX_W-1:0] dot_px [9];
    logic [lmf_pkg::CFG_W-1:0] w, h, thr;
    int                        sent, count, i;
    checker_px = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    dot_px     = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: the start of the first 640-pixel row yields no results.
    for (i = 0; i < 40; i++) send_pixel(lmf_pkg::PIX_W'($urandom_range(0, 255)));

    // Smallest image, threshold of zero: nothing is flat.
    wait_drained();
    write_reg(lmf_pkg::REG_IMAGE_WIDTH, 12'd3);
    write_reg(lmf_pkg::REG_IMAGE_HEIGHT, 12'd3);
    write_reg(lmf_pkg::REG_FLAT_THRESHOLD, 12'd0);
    foreach (checker_px[j]) send_pixel(checker_px[j]);

    // Largest useful threshold: every interior centre is flat; stray index ignored.
    wait_drained();
    write_reg(lmf_pkg::REG_FLAT_THRESHOLD, 12'd1531);
    write_reg(REG_UNUSED, 12'hFFF);
    foreach (dot_px[j]) send_pixel(dot_px[j]);

    // Size written mid-image restarts it; sizes below range clamp to three.
    for (i = 0; i < 4; i++) send_pixel(i[0] ? lmf_pkg::PIX_MAX : 8'd0);
    wait_drained();
    write_reg(lmf_pkg::REG_IMAGE_WIDTH, 12'd0);
    write_reg(lmf_pkg::REG_IMAGE_HEIGHT, 12'd2);
    write_reg(lmf_pkg::REG_FLAT_THRESHOLD, 12'hFFF);
    for (i = 0; i < 3; i++) send_pixel(8'd128);

    // Random images, mostly small.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? lmf_pkg::CFG_W'($urandom_range(0, 2)) :
          ($urandom_range(0, 9) == 0) ? lmf_pkg::CFG_W'($urandom_range(11, 40)) :
                                        lmf_pkg::CFG_W'($urandom_range(3, 10));
      h = ($urandom_range(0, 7) == 0) ? lmf_pkg::CFG_W'($urandom_range(0, 2)) :
                                        lmf_pkg::CFG_W'($urandom_range(3, 6));
      thr = ($urandom_range(0, 3) == 0) ? lmf_pkg::CFG_W'($urandom_range(0, 4095)) :
                                          lmf_pkg::CFG_W'($urandom_range(0, 60));
      count = $urandom_range(8, 60);
      steady_flow = ($urandom_range(0, 4) == 0);
      run_phase(w, h, thr, count, pixel_style_t'($urandom_range(0, 2)));
      sent += count;
    end

    // Widest image setting, clamped from the top of the register range.
    steady_flow = 1'b0;
    run_phase(12'hFFF, 12'd3, 12'd30, 30, PIX_SMOOTH);
    // Tallest image setting, clamped the same way.
    run_phase(12'd3, 12'hFFF, 12'd1531, 30, PIX_NOISE);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== line_mask_flatness_filter.f =====
hdl/lmf_pkg.sv
hdl/lmf_line_store.sv
hdl/lmf_window_cell.sv
hdl/lmf_result_queue.sv
hdl/line_mask_flatness_filter.sv
sim/testbench.sv
